// ===== src/tsgm_pkg.sv =====
// Package for the test signal generator with level meter.
// Holds the request and result types, register indexes and the sine table.
// No dependencies.
`timescale 1ns / 1ps

package tsgm_pkg;

    // Sine quarter-wave table geometry
    localparam int SineDepth = 256;
    localparam int SineIdxW  = $clog2(SineDepth);

    localparam logic [63:0] PiHalfQ30 = 64'd1686629713;

    // Register file (byte address = 4 * index)
    localparam int          RegNum       = 6;
    localparam int          PaddrW       = $clog2(4 * RegNum);
    localparam logic [2:0]  RegMode      = 3'd0;
    localparam logic [2:0]  RegBase      = 3'd1;
    localparam logic [2:0]  RegHigh      = 3'd2;
    localparam logic [2:0]  RegStep      = 3'd3;
    localparam logic [2:0]  RegFps       = 3'd4;
    localparam logic [2:0]  RegRun       = 3'd5;

    // Signal modes
    localparam logic [1:0]  ModeConst    = 2'd0;
    localparam logic [1:0]  ModeAlt      = 2'd1;
    localparam logic [1:0]  ModeSine     = 2'd2;
    localparam logic [1:0]  ModeBeat     = 2'd3;

    // Register reset values
    localparam logic [1:0]  ResetMode    = ModeAlt;
    localparam logic [15:0] ResetBase    = 16'd22938;
    localparam logic [15:0] ResetHigh    = 16'd29491;
    localparam logic [31:0] ResetStep    = 32'd5368709;
    localparam logic [17:0] ResetFps     = 18'd48000;
    localparam logic [15:0] ResetRun     = 16'd0;

    localparam logic [47:0] EnergyMax    = '1;

    typedef struct packed {
        logic beat_known;
        logic beat_odd;
    } t_in;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               window_done;
        logic        [47:0] window_energy;
        logic        [15:0] window_peak;
        logic signed [15:0] window_low;
        logic signed [15:0] window_high;
        logic               run_finished;
    } t_out;

    typedef logic [15:0] t_sine_rom [SineDepth];

    // Quarter-wave sine, Taylor series in unsigned Q30, evaluated at elaboration
    function automatic t_sine_rom f_sine_rom();
        t_sine_rom   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        int          i;
        for (i = 0; i < SineDepth; i++) begin
            x    = (PiHalfQ30 * 64'(2 * i + 1)) / 64'(2 * SineDepth);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            // terms through x^17/17!, odd ones subtract (floored at zero)
            term = ((term * x2) >> 30) / 64'd6;
            sum  = (sum >= term) ? sum - term : 64'd0;
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd42;
            sum  = (sum >= term) ? sum - term : 64'd0;
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd110;
            sum  = (sum >= term) ? sum - term : 64'd0;
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd210;
            sum  = (sum >= term) ? sum - term : 64'd0;
            term = ((term * x2) >> 30) / 64'd272;
            sum  = sum + term;
            r = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
            if (r > 64'd32767) begin
                r = 64'd32767;
            end
            rom[i] = r[15:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SineRom = f_sine_rom();

endpackage

// ===== src/test_signal_generator_with_meter.sv =====
// Test tone generator with one-second level meter, top level.
// Depends on tsgm_pkg (types, register map, sine table).
// Checker tsgm_checker is bound to this module from its own file.
`timescale 1ns / 1ps

//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+---------------------
//  request   | in        | i_in_valid / o_in_ready      | i_in_data  (t_in)
//  result    | out       | o_out_valid / i_out_ready    | o_out_data (t_out)
//  config    | in        | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
//  After acceptance a request passes five sequencer steps (table read, sine
//  product, sample select, square, accumulate) and returns to idle before the
//  next ready. One 17x17 signed multiplier is shared by the sine scaling and the
//  squaring; it sets the step count.
//  The result sits in an output register; a new request is accepted while it
//  waits. The accumulate step stalls only if the previous result is still held.
//  Reset (synchronous, active low) restores register defaults and clears meter.

module test_signal_generator_with_meter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  tsgm_pkg::t_in              i_in_data,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output tsgm_pkg::t_out             o_out_data,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tsgm_pkg::PaddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ROM  = 6'b000010,
        S_MUL  = 6'b000100,
        S_SAMP = 6'b001000,
        S_SQ   = 6'b010000,
        S_ACC  = 6'b100000
    } t_state;

    localparam int IdxW  = tsgm_pkg::SineIdxW;
    localparam int ProdW = 30 + IdxW;

    // ---------------- configuration registers ----------------
    logic        [1:0]  r_mode;
    logic signed [15:0] r_base;
    logic signed [15:0] r_high;
    logic        [31:0] r_step;
    logic        [17:0] r_fps;
    logic        [15:0] r_run;

    logic        [2:0]  reg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[tsgm_pkg::PaddrW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tsgm_pkg::ResetMode;
            r_base <= tsgm_pkg::ResetBase;
            r_high <= tsgm_pkg::ResetHigh;
            r_step <= tsgm_pkg::ResetStep;
            r_fps  <= tsgm_pkg::ResetFps;
            r_run  <= tsgm_pkg::ResetRun;
        end else if (cfg_wr) begin
            case (reg_idx)
                tsgm_pkg::RegMode: r_mode <= pwdata[1:0];
                tsgm_pkg::RegBase: r_base <= pwdata[15:0];
                tsgm_pkg::RegHigh: r_high <= pwdata[15:0];
                tsgm_pkg::RegStep: r_step <= pwdata;
                tsgm_pkg::RegFps:  r_fps  <= pwdata[17:0];
                tsgm_pkg::RegRun:  r_run  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tsgm_pkg::RegMode: prdata = {30'd0, r_mode};
            tsgm_pkg::RegBase: prdata = {16'd0, r_base};
            tsgm_pkg::RegHigh: prdata = {16'd0, r_high};
            tsgm_pkg::RegStep: prdata = r_step;
            tsgm_pkg::RegFps:  prdata = {14'd0, r_fps};
            tsgm_pkg::RegRun:  prdata = {16'd0, r_run};
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------- sequencer and datapath state ----------------
    t_state              r_state;
    t_state              n_state;
    tsgm_pkg::t_in       r_in;
    logic        [31:0]  r_phase;
    logic signed [16:0]  r_rom_s;     // signed table value for this phase
    logic signed [33:0]  r_prod;      // shared multiplier output
    logic signed [15:0]  r_sample;

    // meter / timing state
    logic        [17:0]  r_frame;
    logic                r_sec_odd;
    logic        [15:0]  r_secs;
    logic        [47:0]  r_energy;
    logic        [15:0]  r_peak;
    logic signed [15:0]  r_low;
    logic signed [15:0]  r_high_acc;
    logic                r_finished;

    // output register
    logic                r_out_valid;
    tsgm_pkg::t_out      r_out;

    logic                in_acc;
    logic                commit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    // accumulate step waits for a free output register
    assign commit      = (r_state == S_ACC) && (!r_out_valid || i_out_ready);

    // ---- sine table lookup: quadrant from the top bits, mirror on odd quadrants
    logic [1:0]        quad;
    logic [ProdW-1:0]  idx_full;
    logic [IdxW-1:0]   idx_raw;
    logic [IdxW-1:0]   idx;
    logic [15:0]       rom_val;
    logic signed [16:0] rom_s;

    assign quad     = r_phase[31:30];
    assign idx_full = {{IdxW{1'b0}}, r_phase[29:0]} * ProdW'(tsgm_pkg::SineDepth);
    assign idx_raw  = idx_full[ProdW-1:30];
    assign idx      = quad[0] ? IdxW'(tsgm_pkg::SineDepth - 1) - idx_raw : idx_raw;
    assign rom_val  = tsgm_pkg::SineRom[idx];
    assign rom_s    = quad[1] ? -$signed({1'b0, rom_val}) : $signed({1'b0, rom_val});

    // ---- shared multiplier: base x table in S_MUL, sample x sample in S_SQ
    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] mul_p;

    assign mul_a = (r_state == S_SQ) ? {r_sample[15], r_sample} : {r_base[15], r_base};
    assign mul_b = (r_state == S_SQ) ? {r_sample[15], r_sample} : r_rom_s;
    assign mul_p = mul_a * mul_b;

    // ---- sine sample: round, floor shift by 15, saturate
    logic signed [33:0] rnd;
    logic signed [18:0] shr;
    logic signed [15:0] sine_s;
    logic signed [15:0] pick_s;

    assign rnd = r_prod + 34'sd16384;
    assign shr = rnd[33:15];

    always_comb begin
        if (shr > 19'sd32767) begin
            sine_s = 16'sh7FFF;
        end else if (shr < -19'sd32768) begin
            sine_s = 16'sh8000;
        end else begin
            sine_s = shr[15:0];
        end
    end

    always_comb begin
        case (r_mode)
            tsgm_pkg::ModeConst: pick_s = r_base;
            tsgm_pkg::ModeAlt:   pick_s = r_sec_odd ? r_high : r_base;
            tsgm_pkg::ModeSine:  pick_s = sine_s;
            tsgm_pkg::ModeBeat:  pick_s = (r_in.beat_known && r_in.beat_odd) ? r_high : r_base;
            default:             pick_s = r_base;
        endcase
    end

    // ---- meter update
    logic signed [16:0] s_ext;
    logic        [16:0] mag17;
    logic        [15:0] mag;
    logic        [48:0] e_sum;
    logic        [47:0] energy_n;
    logic        [15:0] peak_n;
    logic signed [15:0] low_n;
    logic signed [15:0] high_n;
    logic        [17:0] fps_eff;
    logic               done;
    logic        [15:0] secs_n;
    logic               fin_n;
    tsgm_pkg::t_out     out_n;

    assign s_ext    = {r_sample[15], r_sample};
    assign mag17    = r_sample[15] ? 17'(-s_ext) : 17'(s_ext);
    assign mag      = mag17[15:0];                  // at most 32768
    assign e_sum    = {1'b0, r_energy} + {18'd0, r_prod[30:0]};
    assign energy_n = e_sum[48] ? tsgm_pkg::EnergyMax : e_sum[47:0];
    assign peak_n   = (mag > r_peak) ? mag : r_peak;
    assign low_n    = (r_sample < r_low) ? r_sample : r_low;
    assign high_n   = (r_sample > r_high_acc) ? r_sample : r_high_acc;
    assign fps_eff  = (r_fps == 18'd0) ? 18'd1 : r_fps;
    assign done     = ({1'b0, r_frame} + 19'd1) >= {1'b0, fps_eff};
    assign secs_n   = (done && (r_secs != 16'hFFFF)) ? r_secs + 16'd1 : r_secs;
    assign fin_n    = r_finished || ((r_run != 16'd0) && (secs_n >= r_run));

    always_comb begin
        out_n              = '0;
        out_n.sample_out   = r_sample;
        out_n.window_done  = done;
        out_n.run_finished = fin_n;
        if (done) begin
            out_n.window_energy = energy_n;
            out_n.window_peak   = peak_n;
            out_n.window_low    = low_n;
            out_n.window_high   = high_n;
        end
    end

    // ---- sequencer
    always_comb begin
        case (r_state)
            S_IDLE:  n_state = in_acc ? S_ROM : S_IDLE;
            S_ROM:   n_state = S_MUL;
            S_MUL:   n_state = S_SAMP;
            S_SAMP:  n_state = S_SQ;
            S_SQ:    n_state = S_ACC;
            S_ACC:   n_state = commit ? S_IDLE : S_ACC;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 32'd0;
            r_frame     <= 18'd0;
            r_sec_odd   <= 1'b0;
            r_secs      <= 16'd0;
            r_energy    <= 48'd0;
            r_peak      <= 16'd0;
            r_low       <= 16'sh7FFF;
            r_high_acc  <= 16'sh8000;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_ROM: begin
                    // table read uses the phase before this frame's step
                    r_phase <= r_phase + r_step;
                end
                S_ACC: begin
                    if (commit) begin
                        r_secs     <= secs_n;
                        r_finished <= fin_n;
                        if (done) begin
                            r_frame    <= 18'd0;
                            r_sec_odd  <= ~r_sec_odd;
                            r_energy   <= 48'd0;
                            r_peak     <= 16'd0;
                            r_low      <= 16'sh7FFF;
                            r_high_acc <= 16'sh8000;
                        end else begin
                            r_frame    <= r_frame + 18'd1;
                            r_energy   <= energy_n;
                            r_peak     <= peak_n;
                            r_low      <= low_n;
                            r_high_acc <= high_n;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (r_state == S_ROM) begin
            r_rom_s <= rom_s;
        end
        if (r_state == S_MUL || r_state == S_SQ) begin
            r_prod <= mul_p;
        end
        if (r_state == S_SAMP) begin
            r_sample <= pick_s;
        end
        if (commit) begin
            r_out <= out_n;
        end
    end

endmodule

// ===== src/tsgm_checker.sv =====
// Port-level checker for the test signal generator with level meter.
// Depends on tsgm_pkg; bound to test_signal_generator_with_meter below.
`timescale 1ns / 1ps

module tsgm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input tsgm_pkg::t_in               i_in_data,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input tsgm_pkg::t_out              o_out_data,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [tsgm_pkg::PaddrW-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata,
    input logic                        pready
);

    logic signed [16:0] lo_ext;
    logic signed [16:0] hi_ext;
    logic        [16:0] lo_abs;
    logic        [16:0] hi_abs;
    logic        [16:0] max_abs;
    logic               unused_ok;

    assign lo_ext  = {o_out_data.window_low[15], o_out_data.window_low};
    assign hi_ext  = {o_out_data.window_high[15], o_out_data.window_high};
    assign lo_abs  = lo_ext[16] ? 17'(-lo_ext) : 17'(lo_ext);
    assign hi_abs  = hi_ext[16] ? 17'(-hi_ext) : 17'(hi_ext);
    assign max_abs = (lo_abs > hi_abs) ? lo_abs : hi_abs;
    assign unused_ok = ^{i_in_data, psel, penable, pwrite, paddr, pwdata, prdata, pready};

    // a request passes through the sequencer: never two accepted back to back
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted on consecutive cycles");

    // open window reports no statistics
    a_idle_window_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.window_done) |->
        (o_out_data.window_energy == 48'd0 && o_out_data.window_peak == 16'd0 &&
         o_out_data.window_low == 16'sd0 && o_out_data.window_high == 16'sd0))
        else $error("statistics on a frame that does not close a window");

    // closed window: min not above max, peak is the larger magnitude
    a_window_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.window_done) |->
        (o_out_data.window_low <= o_out_data.window_high &&
         {1'b0, o_out_data.window_peak} == max_abs))
        else $error("window statistics inconsistent");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

endmodule

bind test_signal_generator_with_meter tsgm_checker u_tsgm_checker (.*);
